// ===== hw/rtl/grid_first_fit_placer_macros.svh =====
// assertion macros for the grid first-fit placer
// clocked on clk, disabled while rst is high; define SYNTH to drop them
`ifndef GRID_FIRST_FIT_PLACER_MACROS_SVH
`define GRID_FIRST_FIT_PLACER_MACROS_SVH
`ifndef SYNTH
`define GFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GFP_ASSERT(lbl, prop, msg)
`define GFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/gfp_pkg.sv =====
// shared types, constants and helpers of the grid first-fit placer
// no dependencies
package gfp_pkg;

  localparam int MAX_COLUMNS   = 16;
  localparam int MAX_GRID_ROWS = 256;
  localparam int MAX_ITEM_SPAN = 16;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W     = $clog2(MAX_GRID_ROWS);
  localparam int ROW_CNT_W = $clog2(MAX_GRID_ROWS + 1);
  localparam int SPAN_W    = $clog2(MAX_ITEM_SPAN + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COL_CNT_W-1:0] GRID_COLUMNS_RESET = COL_CNT_W'(10);
  localparam logic [ROW_CNT_W-1:0] ROW_CEILING_RESET  = ROW_CNT_W'(256);

  typedef logic [MAX_COLUMNS-1:0] row_t;
  typedef logic [ROW_W-1:0]       row_addr_t;
  typedef logic [ROW_CNT_W-1:0]   row_cnt_t;
  typedef logic [COL_W-1:0]       col_t;
  typedef logic [COL_CNT_W-1:0]   col_cnt_t;
  typedef logic [SPAN_W-1:0]      span_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLACE = 2'd1,
    OP_FIT   = 2'd2
  } op_t;

  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_ROW_CEILING  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    col_cnt_t grid_columns;
    row_cnt_t row_ceiling;
  } cfg_t;

  typedef struct packed {
    logic restart;
    logic shift_en;
  } win_ctrl_t;

  typedef struct packed {
    logic      rd_en;
    row_addr_t rd_addr;
    logic      wr_en;
    row_addr_t wr_addr;
    row_t      wr_row;
  } mem_req_t;

  typedef struct packed {
    logic      placed;
    col_t      col;
    row_addr_t row;
    span_t     span_c;
    span_t     span_r;
  } result_t;

  // bits x .. x+w-1 of a row, w from 1 up to MAX_COLUMNS
  function automatic row_t span_mask(input col_t x, input span_t w);
    logic [MAX_COLUMNS:0] ones;
    ones = ({{MAX_COLUMNS{1'b0}}, 1'b1} << w) - 1'b1;
    return ones[MAX_COLUMNS-1:0] << x;
  endfunction

endpackage

// ===== hw/rtl/gfp_cfg_regs.sv =====
// register file of the placer: column count and row ceiling
// depends on gfp_pkg
module gfp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gfp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [gfp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [gfp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output gfp_pkg::cfg_t                       cfg
);
  import gfp_pkg::*;

  cfg_reg_t reg_sel;
  logic     wr_fire;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_columns <= GRID_COLUMNS_RESET;
      cfg.row_ceiling  <= ROW_CEILING_RESET;
    end else if (wr_fire) begin
      case (reg_sel)
        REG_GRID_COLUMNS: cfg.grid_columns <= pwdata[COL_CNT_W-1:0];
        REG_ROW_CEILING:  cfg.row_ceiling  <= pwdata[ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_COLUMNS: prdata = CFG_DATA_W'(cfg.grid_columns);
      REG_ROW_CEILING:  prdata = CFG_DATA_W'(cfg.row_ceiling);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/gfp_occ_mem.sv =====
// occupancy memory: one row word per grid row, registered read, one write port
// per-row valid flops make a cleared or never-written row read as all free
// depends on gfp_pkg and grid_first_fit_placer_macros.svh
module gfp_occ_mem (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear_all,
  input  gfp_pkg::mem_req_t req,
  output gfp_pkg::row_t     rd_row
);
  import gfp_pkg::*;
  `include "grid_first_fit_placer_macros.svh"

  row_t                     mem [MAX_GRID_ROWS];
  logic [MAX_GRID_ROWS-1:0] valid;
  row_t                     rd_data;
  logic                     rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_row;
    end
    if (req.rd_en) begin
      rd_data  <= mem[req.rd_addr];
      rd_valid <= valid[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

  `GFP_ASSERT(a_no_same_row_rw, !(req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr)), "read and write hit the same row in one cycle")
  `GFP_ASSERT_NEXT(a_clear_empties, clear_all, valid == '0, "rows still valid after clear")

endmodule

// ===== hw/rtl/gfp_run_window.sv =====
// per-column free-run counters over the rows streamed in, and the search
// for the leftmost window of free columns that is tall and wide enough
// depends on gfp_pkg and grid_first_fit_placer_macros.svh
module gfp_run_window (
  input  logic               clk,
  input  logic               rst,
  input  gfp_pkg::win_ctrl_t ctrl,
  input  gfp_pkg::row_t      row_in,
  input  gfp_pkg::span_t     height,
  input  gfp_pkg::span_t     width,
  input  gfp_pkg::col_cnt_t  cols,
  output logic               found,
  output gfp_pkg::col_t      found_x
);
  import gfp_pkg::*;
  `include "grid_first_fit_placer_macros.svh"

  span_t                  runs [MAX_COLUMNS];
  row_t                   fit_col;
  logic [MAX_COLUMNS-1:0] win_ok;

  // run length of free cells ending at the latest row, saturating
  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (rst || ctrl.restart) begin
        runs[c] <= '0;
      end else if (ctrl.shift_en) begin
        if (row_in[c]) begin
          runs[c] <= '0;
        end else if (runs[c] != '1) begin
          runs[c] <= runs[c] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      fit_col[c] = (runs[c] >= height) && (COL_CNT_W'(c) < cols);
    end
    for (int x = 0; x < MAX_COLUMNS; x++) begin
      win_ok[x] = ((fit_col | ~span_mask(COL_W'(x), width)) == '1) &&
                  (COL_CNT_W'(x) + COL_CNT_W'(width) <= cols);
    end
    found   = |win_ok;
    found_x = '0;
    for (int x = MAX_COLUMNS - 1; x >= 0; x--) begin
      if (win_ok[x]) found_x = COL_W'(x);
    end
  end

  `GFP_ASSERT_NEXT(a_restart_no_fit, ctrl.restart, !found, "fit reported right after restart")

endmodule

// ===== hw/rtl/grid_first_fit_placer.sv =====
// grid_first_fit_placer: keeps an occupancy bitmap of up to 256 rows of 16
// cells and answers clear, place-at and first-fit requests, one result per
// request. Place-at reads the h covered rows one per cycle to check them
// and reads them again to mark them. First-fit streams rows out of the
// occupancy memory one per cycle, through its single read port, into
// per-column free-run counters. A finished result sits in the output
// register while the next request is already taken. Rows need no clearing
// pass after reset.
// depends on gfp_pkg, gfp_cfg_regs, gfp_occ_mem, gfp_run_window and the macros
module grid_first_fit_placer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // anchor_column[3:0], anchor_row[11:4], item_width[16:12], item_height[21:17]
  input  logic [23:0]                    s_tdata,
  // operation[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // placed_column[3:0], placed_row[11:4], span_columns[16:12],
  // span_rows[21:17], rows_in_use[30:22]
  output logic [31:0]                    m_tdata,
  // placed
  output logic                           m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gfp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gfp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gfp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import gfp_pkg::*;
  `include "grid_first_fit_placer_macros.svh"

  cfg_t      cfg;
  mem_req_t  mem_req;
  row_t      rd_row;
  logic      clear_all;
  win_ctrl_t win_ctrl;
  logic      win_found;
  col_t      win_x;

  state_t    state, state_next;
  col_t      mark_x, mark_x_next;
  row_addr_t mark_y, mark_y_next;
  span_t     w_q, w_q_next;
  span_t     h_q, h_q_next;
  row_t      mask_q, mask_q_next;
  row_cnt_t  row_ptr, row_ptr_next;
  span_t     issue_left, issue_left_next;
  logic      pend, pend_next;
  row_addr_t pend_row, pend_row_next;
  logic      run_ok, run_ok_next;
  row_addr_t run_row, run_row_next;
  logic      hit, hit_next;
  row_cnt_t  used, used_next;
  result_t   res, res_next;
  logic      load_out;

  op_t       in_op;
  col_t      in_ax;
  row_addr_t in_ay;
  span_t     in_w, in_h;
  col_cnt_t  cols_eff;
  row_cnt_t  ceil_eff;
  logic      place_ok, fit_ok;
  row_addr_t fit_row;
  row_cnt_t  mark_end;
  row_cnt_t  out_end;

  gfp_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  gfp_occ_mem u_mem (
    .clk, .rst, .clear_all, .req(mem_req), .rd_row
  );

  gfp_run_window u_win (
    .clk, .rst, .ctrl(win_ctrl), .row_in(rd_row), .height(h_q), .width(w_q),
    .cols(cols_eff), .found(win_found), .found_x(win_x)
  );

  assign in_op = op_t'(s_tuser);
  assign in_ax = s_tdata[3:0];
  assign in_ay = s_tdata[11:4];
  assign in_w  = (s_tdata[16:12] == '0) ? SPAN_W'(1) : s_tdata[16:12];
  assign in_h  = (s_tdata[21:17] == '0) ? SPAN_W'(1) : s_tdata[21:17];

  assign cols_eff = (cfg.grid_columns > COL_CNT_W'(MAX_COLUMNS)) ?
                    COL_CNT_W'(MAX_COLUMNS) : cfg.grid_columns;
  assign ceil_eff = ((cfg.row_ceiling == '0) ||
                     (cfg.row_ceiling > ROW_CNT_W'(MAX_GRID_ROWS))) ?
                    ROW_CNT_W'(MAX_GRID_ROWS) : cfg.row_ceiling;

  assign place_ok = (cols_eff != '0) &&
                    ((COL_CNT_W + 1)'(in_ax) + (COL_CNT_W + 1)'(in_w) <=
                     (COL_CNT_W + 1)'(cols_eff)) &&
                    (ROW_CNT_W'(in_ay) + ROW_CNT_W'(in_h) <= ceil_eff);
  assign fit_ok   = (cols_eff != '0) && (COL_CNT_W'(in_w) <= cols_eff);

  // top row of a window whose bottom row is the one in the run counters
  assign fit_row  = run_row + 1'b1 - ROW_W'(h_q);
  assign mark_end = ROW_CNT_W'(mark_y) + ROW_CNT_W'(h_q);

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    mark_x_next     = mark_x;
    mark_y_next     = mark_y;
    w_q_next        = w_q;
    h_q_next        = h_q;
    mask_q_next     = mask_q;
    row_ptr_next    = row_ptr;
    issue_left_next = issue_left;
    pend_next       = 1'b0;
    pend_row_next   = pend_row;
    run_ok_next     = run_ok;
    run_row_next    = run_row;
    hit_next        = hit;
    used_next       = used;
    res_next        = res;
    mem_req         = '0;
    win_ctrl        = '0;
    clear_all       = 1'b0;
    load_out        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          w_q_next        = in_w;
          h_q_next        = in_h;
          res_next.placed = 1'b0;
          res_next.col    = '0;
          res_next.row    = '0;
          res_next.span_c = in_w;
          res_next.span_r = in_h;
          state_next      = ST_FINISH;
          case (in_op)
            OP_CLEAR: begin
              clear_all       = 1'b1;
              used_next       = '0;
              res_next.span_c = SPAN_W'(1);
              res_next.span_r = SPAN_W'(1);
            end
            OP_PLACE: begin
              if (place_ok) begin
                mark_x_next     = in_ax;
                mark_y_next     = in_ay;
                mask_q_next     = span_mask(in_ax, in_w);
                row_ptr_next    = ROW_CNT_W'(in_ay);
                issue_left_next = in_h;
                hit_next        = 1'b0;
                state_next      = ST_CHECK;
              end
            end
            OP_FIT: begin
              if (fit_ok) begin
                win_ctrl.restart = 1'b1;
                row_ptr_next     = '0;
                run_ok_next      = 1'b0;
                state_next       = ST_SCAN;
              end
            end
            default: begin
              res_next.span_c = SPAN_W'(1);
              res_next.span_r = SPAN_W'(1);
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (pend) begin
          hit_next = hit || ((rd_row & mask_q) != '0);
        end
        if (issue_left != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = row_ptr[ROW_W-1:0];
          row_ptr_next    = row_ptr + 1'b1;
          issue_left_next = issue_left - 1'b1;
          pend_next       = 1'b1;
          pend_row_next   = row_ptr[ROW_W-1:0];
        end else if (!pend) begin
          if (!hit) begin
            row_ptr_next    = ROW_CNT_W'(mark_y);
            issue_left_next = h_q;
            state_next      = ST_MARK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_SCAN: begin
        if (run_ok && win_found) begin
          mark_x_next     = win_x;
          mark_y_next     = fit_row;
          mask_q_next     = span_mask(win_x, w_q);
          row_ptr_next    = ROW_CNT_W'(fit_row);
          issue_left_next = h_q;
          state_next      = ST_MARK;
        end else begin
          win_ctrl.shift_en = pend;
          run_ok_next       = pend;
          run_row_next      = pend_row;
          if (row_ptr < ceil_eff) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = row_ptr[ROW_W-1:0];
            row_ptr_next    = row_ptr + 1'b1;
            pend_next       = 1'b1;
            pend_row_next   = row_ptr[ROW_W-1:0];
          end else if (!pend) begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_MARK: begin
        // write row r back while row r+1 is being read
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = pend_row;
          mem_req.wr_row  = rd_row | mask_q;
        end
        if (issue_left != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = row_ptr[ROW_W-1:0];
          row_ptr_next    = row_ptr + 1'b1;
          issue_left_next = issue_left - 1'b1;
          pend_next       = 1'b1;
          pend_row_next   = row_ptr[ROW_W-1:0];
        end else if (!pend) begin
          if (mark_end > used) begin
            used_next = mark_end;
          end
          res_next.placed = 1'b1;
          res_next.col    = mark_x;
          res_next.row    = mark_y;
          state_next      = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend   <= 1'b0;
      run_ok <= 1'b0;
      used   <= '0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      run_ok <= run_ok_next;
      used   <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    mark_x     <= mark_x_next;
    mark_y     <= mark_y_next;
    w_q        <= w_q_next;
    h_q        <= h_q_next;
    mask_q     <= mask_q_next;
    row_ptr    <= row_ptr_next;
    issue_left <= issue_left_next;
    pend_row   <= pend_row_next;
    run_row    <= run_row_next;
    hit        <= hit_next;
    res        <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, used, res.span_r, res.span_c, res.row, res.col};
      m_tuser <= res.placed;
    end
  end

  assign out_end = ROW_CNT_W'(m_tdata[11:4]) + ROW_CNT_W'(m_tdata[21:17]);

  `GFP_ASSERT(a_write_only_in_mark, !mem_req.wr_en || (state == ST_MARK), "row written outside marking")
  `GFP_ASSERT(a_used_covers_placed, !(m_tvalid && m_tuser) || (m_tdata[30:22] >= out_end), "rows in use below a placed rectangle")
  `GFP_ASSERT_NEXT(a_clear_resets_used, s_tvalid && s_tready && (s_tuser == OP_CLEAR), used == '0, "rows in use not zero after clear")

endmodule
